[rtl/core/pade_tanh_soft_clipper_core_assert.svh]
// ----------------------------------------------------------------------------
// pade_tanh_soft_clipper_core_assert.svh
// Assertion macros used by the soft clipper checker.
// ----------------------------------------------------------------------------
`ifndef PADE_TANH_SOFT_CLIPPER_CORE_ASSERT_SVH
`define PADE_TANH_SOFT_CLIPPER_CORE_ASSERT_SVH

// next-cycle implication, masked while in reset
`define PTSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// same-cycle implication, masked while in reset
`define PTSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked through reset as well
`define PTSC_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/ptsc_pkg.sv]
// ----------------------------------------------------------------------------
// ptsc_pkg
// Widths, constants and word types of the Pade tanh soft clipper.
// ----------------------------------------------------------------------------
`default_nettype none

package ptsc_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int OUT_BITS    = 16;
  localparam int GAIN_W      = 16;
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(4096);

  // curve argument a = |s| * gain in Q.20
  localparam int AFRAC   = 20;
  localparam int FBITS   = SAMPLE_BITS + 7;
  localparam int PM_W    = SAMPLE_BITS + GAIN_W;
  localparam int A_SHIFT = FBITS - AFRAC;
  localparam int A_W     = AFRAC + 2;
  localparam int T_W     = AFRAC + 4;
  localparam int S1_W    = AFRAC + 6;
  localparam int N_W     = A_W + S1_W;
  localparam int DEN_W   = AFRAC + 7;
  localparam int C27     = 27 << AFRAC;

  localparam logic [PM_W-1:0] SAT_LIM = PM_W'(3) << FBITS;

  // divider: y = floor(num * 2^OFRAC / (den * 2^AFRAC))
  localparam int OFRAC  = OUT_BITS - 1;
  localparam int SHL    = (OFRAC >= AFRAC) ? (OFRAC - AFRAC) : 0;
  localparam int SHR    = (AFRAC > OFRAC) ? (AFRAC - OFRAC) : 0;
  localparam int DIVD_W = N_W + SHL;
  localparam int DV_W   = DEN_W + SHR;
  localparam int Q_W    = OFRAC + 2;
  localparam int CW     = (DIVD_W > DV_W + Q_W) ? DIVD_W : (DV_W + Q_W);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          last_in;
  } ptsc_in_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] clipped_out;
    logic                       last_out;
  } ptsc_out_t;

endpackage

`default_nettype wire

[rtl/core/pade_tanh_soft_clipper_core.sv]
// ----------------------------------------------------------------------------
// pade_tanh_soft_clipper_core
// Path: stage 1, stage 2, divider entry and bit stages, then output register.
// Throughput: one word per clock while out_ready holds; set by the restoring divider, one bit a stage.
// Reset: synchronous rst_n clears all stage valids, gain returns to unity.
// ----------------------------------------------------------------------------
`default_nettype none

module pade_tanh_soft_clipper_core
  import ptsc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire ptsc_in_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ptsc_out_t              out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [GAIN_W-1:0] cfg_data
);

  localparam int NST = 3 + Q_W;
  localparam logic [Q_W-1:0] ONE_Q = Q_W'(1) << OFRAC;

  typedef struct packed {
    logic neg;
    logic last;
    logic sat;
  } ctl_t;

  logic [GAIN_W-1:0] gain_r;

  logic [NST-1:0] vld_r;
  logic [NST-1:0] vld_nxt;
  logic [NST-1:0] adv;
  logic           out_adv;

  // stage 1: |sample| * gain
  logic                   s1_neg_r, s1_last_r;
  logic [PM_W-1:0]        s1_pmag_r;
  logic [SAMPLE_BITS-1:0] smag;
  logic [PM_W-1:0]        s1_pmag_nxt;

  // stage 2: a and t = a^2
  ctl_t             s2_ctl_r;
  logic [A_W-1:0]   s2_a_r;
  logic [T_W-1:0]   s2_t_r;
  logic [A_W-1:0]   a_nxt;
  logic [2*A_W-1:0] sq;

  // divider stages, entry 0 holds the dividend
  ctl_t             dv_ctl_r [Q_W+1];
  logic [CW-1:0]    rem_r    [Q_W+1];
  logic [DV_W-1:0]  dvs_r    [Q_W+1];
  logic [Q_W-1:0]   quo_r    [Q_W+1];
  ctl_t             dv_ctl_nxt [Q_W+1];
  logic [CW-1:0]    rem_nxt    [Q_W+1];
  logic [DV_W-1:0]  dvs_nxt    [Q_W+1];
  logic [Q_W-1:0]   quo_nxt    [Q_W+1];

  logic [S1_W-1:0]  sum1;
  logic [N_W-1:0]   num;
  logic [DEN_W-1:0] den;

  logic             out_valid_r;
  ptsc_out_t        out_data_r;
  ptsc_out_t        out_nxt;
  logic [Q_W-1:0]   ymag;
  logic [OUT_BITS-1:0] res;

  // handshake
  assign cfg_ready = 1'b1;
  assign out_adv   = !out_valid_r || out_ready;
  assign adv[NST-1] = !vld_r[NST-1] || out_adv;

  for (genvar k = 0; k < NST - 1; k++) begin : g_adv
    assign adv[k] = !vld_r[k] || adv[k+1];
  end

  assign in_ready = adv[0];

  always_comb begin
    vld_nxt = vld_r;
    for (int k = 0; k < NST; k++) begin
      if (adv[k]) begin
        vld_nxt[k] = (k == 0) ? in_valid : vld_r[(k == 0) ? 0 : k - 1];
      end
    end
  end

  // stage 1
  assign smag        = in_data.sample_in[SAMPLE_BITS-1] ?
                       (~in_data.sample_in + SAMPLE_BITS'(1)) : in_data.sample_in;
  assign s1_pmag_nxt = PM_W'(smag) * PM_W'(gain_r);

  // stage 2
  assign a_nxt = s1_pmag_r[A_SHIFT +: A_W];
  assign sq    = (2*A_W)'(a_nxt) * (2*A_W)'(a_nxt);

  // stage 3: numerator and denominator
  assign sum1 = S1_W'(C27) + S1_W'(s2_t_r);
  assign num  = N_W'(s2_a_r) * N_W'(sum1);
  assign den  = DEN_W'(C27) + DEN_W'({s2_t_r, 3'b000}) + DEN_W'(s2_t_r);

  assign dv_ctl_nxt[0] = s2_ctl_r;
  assign rem_nxt[0]    = CW'(DIVD_W'(num) << SHL);
  assign dvs_nxt[0]    = DV_W'(den) << SHR;
  assign quo_nxt[0]    = '0;

  // restoring divider, one quotient bit a stage
  for (genvar p = 1; p <= Q_W; p++) begin : g_div
    localparam int BIT = Q_W - p;
    logic [CW-1:0] cand;
    logic          ge;
    assign cand          = CW'(dvs_r[p-1]) << BIT;
    assign ge            = rem_r[p-1] >= cand;
    assign rem_nxt[p]    = ge ? (rem_r[p-1] - cand) : rem_r[p-1];
    assign quo_nxt[p]    = quo_r[p-1] | (Q_W'(ge) << BIT);
    assign dvs_nxt[p]    = dvs_r[p-1];
    assign dv_ctl_nxt[p] = dv_ctl_r[p-1];
  end

  // output: clamp, sign, saturate
  always_comb begin
    if (dv_ctl_r[Q_W].sat || (quo_r[Q_W] > ONE_Q)) begin
      ymag = ONE_Q;
    end else begin
      ymag = quo_r[Q_W];
    end
    if (dv_ctl_r[Q_W].neg) begin
      res = '0 - ymag[OUT_BITS-1:0];
    end else if (ymag >= ONE_Q) begin
      res = ONE_Q[OUT_BITS-1:0] - OUT_BITS'(1);
    end else begin
      res = ymag[OUT_BITS-1:0];
    end
    out_nxt.clipped_out = signed'(res);
    out_nxt.last_out    = dv_ctl_r[Q_W].last;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r      <= GAIN_RESET;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        gain_r <= cfg_data;
      end
      vld_r <= vld_nxt;
      if (out_adv) begin
        out_valid_r <= vld_r[NST-1];
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_neg_r  <= in_data.sample_in[SAMPLE_BITS-1];
      s1_last_r <= in_data.last_in;
      s1_pmag_r <= s1_pmag_nxt;
    end
    if (adv[1]) begin
      s2_ctl_r.neg  <= s1_neg_r;
      s2_ctl_r.last <= s1_last_r;
      s2_ctl_r.sat  <= s1_pmag_r >= SAT_LIM;
      s2_a_r        <= a_nxt;
      s2_t_r        <= sq[AFRAC +: T_W];
    end
    for (int p = 0; p <= Q_W; p++) begin
      if (adv[p+2]) begin
        dv_ctl_r[p] <= dv_ctl_nxt[p];
        rem_r[p]    <= rem_nxt[p];
        dvs_r[p]    <= dvs_nxt[p];
        quo_r[p]    <= quo_nxt[p];
      end
    end
    if (out_adv) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[rtl/core/ptsc_checker.sv]
// ----------------------------------------------------------------------------
// ptsc_checker
// Port-level checks on the soft clipper core, bound to the core module.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pade_tanh_soft_clipper_core_assert.svh"

module ptsc_checker
  import ptsc_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire ptsc_in_t          in_data,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire ptsc_out_t         out_data,
  input wire logic              cfg_valid,
  input wire logic              cfg_ready,
  input wire logic [GAIN_W-1:0] cfg_data
);

  logic unused_ok;
  assign unused_ok = in_valid ^ (^in_data) ^ cfg_valid ^ cfg_ready ^ (^cfg_data);

  // stalled result word holds
  `PTSC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result word changed while stalled")

  // a free output register lets the whole pipe take a word
  `PTSC_ASSERT_NOW(a_in_free, !out_valid || out_ready, in_ready, "input blocked with output free")

  // reset empties the output
  `PTSC_ASSERT_RST(a_rst_empty, !rst_n, !out_valid, "result word valid after reset")

endmodule

bind pade_tanh_soft_clipper_core ptsc_checker u_ptsc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .cfg_data  (cfg_data)
);

`default_nettype wire

[bench/pade_tanh_soft_clipper_core_tb.sv]
// ----------------------------------------------------------------------------
// pade_tanh_soft_clipper_core_tb
// Self-checking bench for the Pade tanh soft clipper. Samples are fed through
// a valid/ready driver and the clipped words are compared with a local model
// of the curve, knee short-circuit and Q1.15 saturation. The drive gain is
// reprogrammed between phases, and the phases vary sender and receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module pade_tanh_soft_clipper_core_tb;
  import ptsc_pkg::*;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  ptsc_in_t          in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  ptsc_out_t         out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [GAIN_W-1:0] cfg_data  = '0;

  ptsc_in_t          samples_to_send[$];
  ptsc_out_t         clipped_due[$];
  logic [GAIN_W-1:0] gain_now      = GAIN_RESET;
  int                send_idle_pct = 0;
  int                stall_pct     = 0;
  int                mismatches    = 0;

  pade_tanh_soft_clipper_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // soft clip of one sample at the given gain
  function automatic ptsc_out_t clip_curve(input ptsc_in_t w, input logic [GAIN_W-1:0] g);
    ptsc_out_t   r;
    logic        neg;
    logic [63:0] mag, prod, a, t, num, den, q, rem, y, yneg;
    neg = w.sample_in[SAMPLE_BITS-1];
    mag = {{(64-SAMPLE_BITS){1'b0}}, w.sample_in};
    if (neg) mag = (64'd1 << SAMPLE_BITS) - mag;
    prod = mag * {48'd0, g};
    if (prod >= (64'd3 << FBITS)) begin
      y = 64'd1 << (OUT_BITS - 1);
    end else begin
      a   = prod >> (FBITS - AFRAC);
      t   = (a * a) >> AFRAC;
      num = a * ((64'd27 << AFRAC) + t);
      den = (64'd27 << AFRAC) + 64'd9 * t;
      q   = num / den;
      rem = num % den;
      y   = ((q << (OUT_BITS - 1)) + ((rem << (OUT_BITS - 1)) / den)) >> AFRAC;
    end
    if (y > (64'd1 << (OUT_BITS - 1))) y = 64'd1 << (OUT_BITS - 1);
    if (neg) begin
      yneg = 64'd0 - y;
      r.clipped_out = yneg[OUT_BITS-1:0];
    end else begin
      if (y > (64'd1 << (OUT_BITS - 1)) - 64'd1) y = (64'd1 << (OUT_BITS - 1)) - 64'd1;
      r.clipped_out = y[OUT_BITS-1:0];
    end
    r.last_out = w.last_in;
    return r;
  endfunction

  // random sample, weighted towards the curved region below the knee
  function automatic ptsc_in_t pick_sample(input logic [GAIN_W-1:0] g);
    ptsc_in_t    w;
    logic [63:0] lim, smag, v;
    logic        neg;
    int          kind;
    kind = $urandom_range(9);
    neg  = 1'($urandom_range(1));
    if (kind < 4 || g == 0) begin
      v = {32'd0, $urandom};
    end else if (kind < 9) begin
      lim = (64'd3 << FBITS) / g;
      if (lim > (64'd1 << (SAMPLE_BITS - 1))) lim = 64'd1 << (SAMPLE_BITS - 1);
      smag = 64'($urandom_range(lim[31:0]));
      if (!neg && smag == (64'd1 << (SAMPLE_BITS - 1))) smag = smag - 64'd1;
      v = neg ? 64'd0 - smag : smag;
    end else begin
      case ($urandom_range(4))
        0: v = 64'd0;
        1: v = 64'd1;
        2: v = ~64'd0;
        3: v = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
        default: v = 64'd1 << (SAMPLE_BITS - 1);
      endcase
    end
    w.sample_in = v[SAMPLE_BITS-1:0];
    w.last_in   = ($urandom_range(7) == 0);
    return w;
  endfunction

  task automatic queue_sample(input int s, input logic last);
    ptsc_in_t w;
    w.sample_in = s[SAMPLE_BITS-1:0];
    w.last_in   = last;
    samples_to_send.push_back(w);
  endtask

  task automatic wait_drained;
    do @(posedge clk);
    while (samples_to_send.size() != 0 || in_valid || clipped_due.size() != 0);
  endtask

  task automatic write_gain(input logic [GAIN_W-1:0] g);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= g;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    gain_now = g;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) clipped_due.push_back(clip_curve(in_data, gain_now));
      if (!in_valid || in_ready) begin
        if (samples_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= samples_to_send.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    ptsc_out_t due;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (clipped_due.size() == 0) begin
          mismatches++;
          $display("%0t: expected no word, got clipped %0d last %0b", $time,
                   out_data.clipped_out, out_data.last_out);
        end else begin
          due = clipped_due.pop_front();
          if (out_data.clipped_out !== due.clipped_out) begin
            mismatches++;
            $display("%0t: clipped expected %0d got %0d", $time,
                     due.clipped_out, out_data.clipped_out);
          end
          if (out_data.last_out !== due.last_out) begin
            mismatches++;
            $display("%0t: last expected %0b got %0b", $time,
                     due.last_out, out_data.last_out);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    logic [GAIN_W-1:0] phase_gain [8];
    int                idle_mode;
    phase_gain = '{16'd65535, 16'd1, 16'd4096, 16'd8192, 16'd0, 16'd2048, 16'd12288,
                   16'd40000};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // unity gain: zero, extremes, +-1.0, knee at 3.0, alternating bit patterns
    queue_sample(0, 1'b0);
    queue_sample(1, 1'b1);
    queue_sample(-1, 1'b0);
    queue_sample(8388607, 1'b1);
    queue_sample(-8388608, 1'b0);
    queue_sample(524288, 1'b1);
    queue_sample(-524288, 1'b0);
    queue_sample(1572864, 1'b1);
    queue_sample(-1572864, 1'b0);
    queue_sample(1572863, 1'b1);
    queue_sample(-1572863, 1'b0);
    queue_sample(262144, 1'b1);
    queue_sample(-262144, 1'b0);
    queue_sample(1048576, 1'b1);
    queue_sample(5592405, 1'b0);
    queue_sample(-5592406, 1'b1);
    queue_sample(2, 1'b0);
    queue_sample(100000, 1'b1);
    wait_drained;

    // zero gain
    write_gain(16'd0);
    queue_sample(8388607, 1'b1);
    queue_sample(-8388608, 1'b0);
    queue_sample(12345, 1'b1);
    wait_drained;

    // full gain, just below the knee
    write_gain(16'hFFFF);
    queue_sample(1, 1'b0);
    queue_sample(-1, 1'b1);
    queue_sample(98304, 1'b0);
    wait_drained;

    for (int p = 0; p < 8; p++) begin
      write_gain((p == 4) ? GAIN_W'($urandom_range(65535)) : phase_gain[p]);
      idle_mode = p % 4;
      send_idle_pct = (idle_mode == 1) ? 69 : (idle_mode == 3) ? 15 : 0;
      stall_pct     = (idle_mode == 2) ? 69 : (idle_mode == 3) ? 15 : 0;
      for (int i = 0; i < 160; i++) samples_to_send.push_back(pick_sample(gain_now));
      wait_drained;
    end

    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
